### src/ihsp_pkg.sv
package ihsp_pkg;

  localparam int POS_W = 5;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_GIF     = 4'd1,
    PH_PNG     = 4'd2,
    PH_JSIG    = 4'd3,
    PH_JMARK   = 4'd4,
    PH_JCODE   = 4'd5,
    PH_JLENHI  = 4'd6,
    PH_JLENLO  = 4'd7,
    PH_JSLENHI = 4'd8,
    PH_JSLENLO = 4'd9,
    PH_JSKIP   = 4'd10,
    PH_JBODY   = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SMALL     = 2'd1,
    ST_SIGNATURE = 2'd2,
    ST_NOTFOUND  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FMT_GIF  = 2'd0,
    FMT_JPEG = 2'd1,
    FMT_PNG  = 2'd2,
    FMT_BAD  = 2'd3
  } format_t;

  localparam logic [7:0] GIF_SIG [3] = '{8'h47, 8'h49, 8'h46};
  localparam logic [7:0] PNG_SIG [4] = '{8'h49, 8'h48, 8'h44, 8'h52};

  localparam logic [7:0] JPEG_MARK = 8'hFF;
  localparam logic [7:0] JPEG_SOI  = 8'hD8;
  localparam logic [7:0] SOF_LO    = 8'hC0;
  localparam logic [7:0] SOF_HI    = 8'hC3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  status;
  } out_item_t;

endpackage

### src/ihsp_core.sv
module ihsp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  ihsp_pkg::in_item_t item,
  input  logic [1:0]         image_format,
  output logic               emit,
  output ihsp_pkg::out_item_t result
);
  import ihsp_pkg::*;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   position, position_next;
  logic [15:0]        skip, skip_next;
  logic [15:0]        width_cap, width_cap_next;
  logic [15:0]        height_cap, height_cap_next;
  logic               sig_good, sig_good_next;
  logic               done, done_next;
  status_t            st;

  always_comb begin
    logic [7:0]       b;
    logic [POS_W-1:0] p;
    logic [15:0]      len;
    b               = item.byte_value;
    p               = '0;
    phase_next      = item.first_byte ? PH_START : phase;
    position_next   = item.first_byte ? '0 : position;
    sig_good_next   = item.first_byte ? 1'b1 : sig_good;
    done_next       = item.first_byte ? 1'b0 : done;
    skip_next       = item.first_byte ? '0 : skip;
    width_cap_next  = width_cap;
    height_cap_next = height_cap;
    emit            = 1'b0;
    st              = ST_OK;
    len             = '0;

    if (!done_next) begin
      if (phase_next == PH_START) begin
        position_next = '0;
        case (format_t'(image_format))
          FMT_GIF:  phase_next = PH_GIF;
          FMT_JPEG: phase_next = PH_JSIG;
          FMT_PNG:  phase_next = PH_PNG;
          default: begin
            emit = 1'b1;
            st   = ST_SIGNATURE;
          end
        endcase
      end

      p = position_next;
      if (!emit) begin
        case (phase_next)
          PH_GIF: begin
            if (p < POS_W'(3) && b != GIF_SIG[p[1:0]]) sig_good_next = 1'b0;
            if (p == POS_W'(6)) width_cap_next[7:0]   = b;
            if (p == POS_W'(7)) width_cap_next[15:8]  = b;
            if (p == POS_W'(8)) height_cap_next[7:0]  = b;
            if (p == POS_W'(9)) height_cap_next[15:8] = b;
            if (p == POS_W'(12)) begin
              emit = 1'b1;
              st   = sig_good_next ? ST_OK : ST_SIGNATURE;
            end else begin
              position_next = p + POS_W'(1);
            end
          end
          PH_PNG: begin
            if (p >= POS_W'(12) && p < POS_W'(16) && b != PNG_SIG[p[1:0]])
              sig_good_next = 1'b0;
            if (p == POS_W'(18)) width_cap_next[15:8]  = b;
            if (p == POS_W'(19)) width_cap_next[7:0]   = b;
            if (p == POS_W'(22)) height_cap_next[15:8] = b;
            if (p == POS_W'(23)) begin
              height_cap_next[7:0] = b;
              emit = 1'b1;
              st   = sig_good_next ? ST_OK : ST_SIGNATURE;
            end else begin
              position_next = p + POS_W'(1);
            end
          end
          PH_JSIG: begin
            if (p == '0) begin
              if (b != JPEG_MARK) sig_good_next = 1'b0;
              position_next = POS_W'(1);
            end else if (b != JPEG_SOI || !sig_good_next) begin
              emit = 1'b1;
              st   = ST_SIGNATURE;
            end else begin
              phase_next = PH_JMARK;
            end
          end
          PH_JMARK: begin
            if (b != JPEG_MARK) begin
              emit = 1'b1;
              st   = ST_NOTFOUND;
            end else begin
              phase_next = PH_JCODE;
            end
          end
          PH_JCODE: begin
            phase_next = (b inside {[SOF_LO:SOF_HI]}) ? PH_JSLENHI : PH_JLENHI;
          end
          PH_JLENHI: begin
            skip_next  = {b, 8'h00};
            phase_next = PH_JLENLO;
          end
          PH_JLENLO: begin
            len = skip_next | {8'h00, b};
            if (len < 16'd2) begin
              skip_next = len;
              emit      = 1'b1;
              st        = ST_NOTFOUND;
            end else begin
              skip_next  = len - 16'd2;
              phase_next = (len == 16'd2) ? PH_JMARK : PH_JSKIP;
            end
          end
          PH_JSKIP: begin
            skip_next = skip_next - 16'd1;
            if (skip_next == '0) phase_next = PH_JMARK;
          end
          PH_JSLENHI: phase_next = PH_JSLENLO;
          PH_JSLENLO: begin
            phase_next    = PH_JBODY;
            position_next = '0;
          end
          PH_JBODY: begin
            if (p == POS_W'(1)) height_cap_next[15:8] = b;
            if (p == POS_W'(2)) height_cap_next[7:0]  = b;
            if (p == POS_W'(3)) width_cap_next[15:8]  = b;
            if (p == POS_W'(4)) width_cap_next[7:0]   = b;
            if (p >= POS_W'(5)) begin
              emit = 1'b1;
              st   = ST_OK;
            end else begin
              position_next = p + POS_W'(1);
            end
          end
          default: begin
            emit = 1'b1;
            st   = ST_NOTFOUND;
          end
        endcase
      end

      if (!emit && item.last_byte) begin
        emit = 1'b1;
        if (phase_next == PH_GIF || phase_next == PH_PNG || phase_next == PH_JSIG)
          st = ST_SMALL;
        else
          st = ST_NOTFOUND;
      end

      if (emit) done_next = 1'b1;
    end
  end

  assign result.image_width  = (st == ST_OK) ? width_cap_next : 16'd0;
  assign result.image_height = (st == ST_OK) ? height_cap_next : 16'd0;
  assign result.status       = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      position <= '0;
      skip     <= '0;
      sig_good <= 1'b1;
      done     <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      position <= position_next;
      skip     <= skip_next;
      sig_good <= sig_good_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      width_cap  <= width_cap_next;
      height_cap <= height_cap_next;
    end
  end

endmodule

### src/ihsp_out_reg.sv
module ihsp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ihsp_pkg::out_item_t load_data,
  output logic                free,
  output logic                size_valid,
  input  logic                size_ready,
  output ihsp_pkg::out_item_t size_data
);
  import ihsp_pkg::*;

  assign free = !size_valid || size_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_valid <= 1'b0;
    end else if (load) begin
      size_valid <= 1'b1;
    end else if (size_ready) begin
      size_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      size_data <= load_data;
    end
  end

endmodule

### src/image_header_size_parser_top.sv
// channel  direction  payload                                   handshake
// byte     in         byte_value, first_byte, last_byte          byte_valid / byte_ready
// size     out        image_width, image_height, status          size_valid / size_ready
// cfg      in         image_format (2 bits)                      cfg_valid / cfg_ready
//
// One byte per cycle while byte_ready is high; parser state updates at the byte transfer.
// A result appears in the output register the cycle after its deciding byte.
// byte_ready drops only while a result waits and size_ready is low.
// cfg_ready is always high; the format is sampled at each first byte.
// Synchronous reset, format resets to JPEG.
module image_header_size_parser_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  ihsp_pkg::in_item_t  byte_data,
  output logic                size_valid,
  input  logic                size_ready,
  output ihsp_pkg::out_item_t size_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);
  import ihsp_pkg::*;

  logic       accept;
  logic       emit;
  logic       free;
  logic [1:0] image_format;
  out_item_t  result;

  assign cfg_ready  = 1'b1;
  assign byte_ready = free;
  assign accept     = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_format <= FMT_JPEG;
    end else if (cfg_valid && cfg_ready) begin
      image_format <= cfg_data;
    end
  end

  ihsp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (byte_data),
    .image_format (image_format),
    .emit         (emit),
    .result       (result)
  );

  ihsp_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && emit),
    .load_data  (result),
    .free       (free),
    .size_valid (size_valid),
    .size_ready (size_ready),
    .size_data  (size_data)
  );

endmodule

### src/ihsp_checker.sv
module ihsp_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_ready,
  input logic                size_valid,
  input logic                size_ready,
  input ihsp_pkg::out_item_t size_data
);
  import ihsp_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    size_valid && !size_ready |=> size_valid)
    else $error("size_valid dropped before transfer");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    size_valid && !size_ready |=> $stable(size_data))
    else $error("size_data changed while stalled");

  a_zero_size: assert property (@(posedge clk) disable iff (rst)
    size_valid && size_data.status != ST_OK |->
      size_data.image_width == 16'd0 && size_data.image_height == 16'd0)
    else $error("nonzero size with error status");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> size_valid && !size_ready)
    else $error("byte_ready low without output stall");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !size_valid)
    else $error("size_valid set after reset");

endmodule

bind image_header_size_parser_top ihsp_checker u_chk (.*);
